// ===== design/assert_macros.svh =====
// Assertion macros used by the span timer sample ring.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(name, a, b) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("%m: implication failed");
// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(name, a, b) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error("%m: next-cycle implication failed");
`endif

// ===== design/stsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Span timer package
// Sizes, codes and the ring entry layout shared by the span timer files.
// ----------------------------------------------------------------------------
package stsr_pkg;
  localparam int TIMER_COUNT = 16;
  localparam int RING_DEPTH  = 64;
  localparam int TID_W  = $clog2(TIMER_COUNT);
  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam int ADDR_W = TID_W + SLOT_W;
  localparam int CNT_W  = SLOT_W + 1;
  localparam int CTR_W  = ADDR_W + 1;

  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_STOP  = 3'd1,
    OP_RESET = 3'd2,
    OP_FRAME = 3'd3,
    OP_STATS = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_START, S_STOP_RD, S_STOP_WR,
    S_TRESET, S_STAT_RD, S_STAT_ACC, S_RESP
  } state_e;

  typedef struct packed {
    logic [63:0] start_ns;
    logic [63:0] end_ns;
    logic [63:0] start_cyc;
    logic [63:0] span_ns;
    logic [63:0] span_cyc;
  } entry_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [63:0]      min_ns;
    logic [63:0]      max_ns;
    logic [63:0]      sum_ns;
    logic [63:0]      min_cyc;
    logic [63:0]      max_cyc;
    logic [63:0]      sum_cyc;
  } stats_t;
endpackage

// ===== design/stsr_ring_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Span timer sample ring memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stsr_ring_mem (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [stsr_pkg::ADDR_W-1:0] waddr_i,
  input  stsr_pkg::entry_t      wdata_i,
  input  logic [stsr_pkg::ADDR_W-1:0] raddr_i,
  output stsr_pkg::entry_t      rdata_o
);
  import stsr_pkg::*;

  entry_t mem_q [TIMER_COUNT*RING_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== design/stsr_stats_acc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Span timer statistics accumulator
// Folds one sample per enabled cycle into minimum, maximum, sum and count.
// ----------------------------------------------------------------------------
module stsr_stats_acc (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clr_i,
  input  logic              en_i,
  input  logic [63:0]       span_ns_i,
  input  logic [63:0]       span_cyc_i,
  output stsr_pkg::stats_t  stats_o
);
  import stsr_pkg::*;

  stats_t acc_q, acc_d;

  always_comb begin
    acc_d = acc_q;
    if (clr_i) begin
      acc_d = '0;
      acc_d.min_ns  = '1;
      acc_d.min_cyc = '1;
    end else if (en_i) begin
      acc_d.count = acc_q.count + 1'b1;
      if (span_ns_i < acc_q.min_ns) acc_d.min_ns = span_ns_i;
      if (span_ns_i > acc_q.max_ns) acc_d.max_ns = span_ns_i;
      acc_d.sum_ns = acc_q.sum_ns + span_ns_i;
      if (span_cyc_i < acc_q.min_cyc) acc_d.min_cyc = span_cyc_i;
      if (span_cyc_i > acc_q.max_cyc) acc_d.max_cyc = span_cyc_i;
      acc_d.sum_cyc = acc_q.sum_cyc + span_cyc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_comb begin
    stats_o = '0;
    if (acc_q.count != '0) begin
      stats_o = acc_q;
    end
  end
endmodule

// ===== design/span_timer_sample_ring.sv =====
`timescale 1ns / 1ps
// Command flow: a start writes a new ring entry; a stop reads the open entry and
// writes it back with its span; a timer reset clears every slot of that timer's ring;
// a stats query reads the timer's samples in turn and folds them; frame begin, no-op
// and any command that finds nothing to do go straight to the response. A command is taken only while busy is low.
// After reset a clearing pass over the whole ring memory holds busy high.
// The done_o strobe lasts one cycle and the receiver cannot stall it.
// ----------------------------------------------------------------------------
// Span timer sample ring
// Per-timer sample rings with start, stop, reset and min/max/sum statistics.
// ----------------------------------------------------------------------------
module span_timer_sample_ring (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation_i,
  input  logic [3:0]  timer_id_i,
  input  logic [63:0] time_ns_i,
  input  logic [63:0] cycle_stamp_i,
  output logic        done_o,
  output logic        status_o,
  output logic [63:0] last_ns_o,
  output logic [63:0] last_cyc_o,
  output logic [63:0] runs_done_o,
  output logic [6:0]  valid_samples_o,
  output logic [63:0] min_ns_o,
  output logic [63:0] max_ns_o,
  output logic [63:0] sum_ns_o,
  output logic [63:0] min_cyc_o,
  output logic [63:0] max_cyc_o,
  output logic [63:0] sum_cycles_o,
  output logic [7:0]  nest_level_o
);
  import stsr_pkg::*;
  `include "assert_macros.svh"

  state_e state_q, state_d;
  logic [2:0]        op_q;
  logic [TID_W-1:0]  tid_q;
  logic [63:0]       tn_q, cy_q;
  logic              status_q;
  logic [7:0]        depth_q;
  logic [CTR_W-1:0]  ctr_q;

  logic              known_q [TIMER_COUNT];
  logic [SLOT_W-1:0] slot_q  [TIMER_COUNT];
  logic [CNT_W-1:0]  fcnt_q  [TIMER_COUNT];
  logic [63:0]       runs_q  [TIMER_COUNT];
  logic [63:0]       lns_q   [TIMER_COUNT];
  logic [63:0]       lcy_q   [TIMER_COUNT];

  logic              accept;
  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  entry_t            wdata, rdata;
  logic              acc_clr, acc_en;
  stats_t            stats;
  logic [SLOT_W-1:0] cur_slot, new_slot;

  assign accept   = start && !busy;
  assign busy     = (state_q != S_IDLE);
  assign done_o   = (state_q == S_RESP);
  assign cur_slot = slot_q[tid_q];
  assign new_slot = known_q[tid_q] ? cur_slot + 1'b1 : '0;

  always_comb begin
    state_d = state_q;
    we      = 1'b0;
    waddr   = {tid_q, cur_slot};
    wdata   = '0;
    raddr   = {tid_q, cur_slot - ctr_q[SLOT_W-1:0]};
    acc_clr = accept;
    acc_en  = 1'b0;
    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = ctr_q[ADDR_W-1:0];
        if (ctr_q[ADDR_W-1:0] == '1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (op_e'(operation_i))
            OP_START: state_d = S_START;
            OP_STOP:  state_d = known_q[timer_id_i] ? S_STOP_RD : S_RESP;
            OP_RESET: state_d = known_q[timer_id_i] ? S_TRESET : S_RESP;
            OP_STATS: state_d = (known_q[timer_id_i] && fcnt_q[timer_id_i] != '0)
                                ? S_STAT_RD : S_RESP;
            default:  state_d = S_RESP;
          endcase
        end
      end
      S_START: begin
        we             = 1'b1;
        waddr          = {tid_q, new_slot};
        wdata.start_ns = tn_q;
        wdata.start_cyc = cy_q;
        state_d        = S_RESP;
      end
      S_STOP_RD: state_d = S_STOP_WR;
      S_STOP_WR: begin
        we              = 1'b1;
        wdata.start_ns  = rdata.start_ns;
        wdata.start_cyc = rdata.start_cyc;
        wdata.end_ns    = tn_q;
        wdata.span_ns   = tn_q - rdata.start_ns;
        wdata.span_cyc  = cy_q - rdata.start_cyc;
        state_d         = S_RESP;
      end
      S_TRESET: begin
        we    = 1'b1;
        waddr = {tid_q, ctr_q[SLOT_W-1:0]};
        if (ctr_q[SLOT_W-1:0] == '1) state_d = S_RESP;
      end
      S_STAT_RD: state_d = S_STAT_ACC;
      S_STAT_ACC: begin
        acc_en  = !(rdata.end_ns == '0 && rdata.start_ns != '0);
        if (ctr_q[CNT_W-1:0] + 1'b1 == fcnt_q[tid_q]) state_d = S_RESP;
        else state_d = S_STAT_RD;
      end
      S_RESP:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      status_q <= 1'b0;
      depth_q  <= '0;
      ctr_q    <= '0;
      for (int i = 0; i < TIMER_COUNT; i++) begin
        known_q[i] <= 1'b0;
        slot_q[i]  <= '0;
        fcnt_q[i]  <= '0;
        runs_q[i]  <= '0;
        lns_q[i]   <= '0;
        lcy_q[i]   <= '0;
      end
    end else begin
      state_q <= state_d;
      case (state_q)
        S_CLEAR: ctr_q <= ctr_q + 1'b1;
        S_IDLE: begin
          ctr_q <= '0;
          if (accept) begin
            status_q <= ((op_e'(operation_i) == OP_STOP) ||
                         (op_e'(operation_i) == OP_STATS)) && !known_q[timer_id_i];
            if (op_e'(operation_i) == OP_FRAME) depth_q <= '0;
          end
        end
        S_START: begin
          if (depth_q != '1) depth_q <= depth_q + 1'b1;
          slot_q[tid_q]  <= new_slot;
          known_q[tid_q] <= 1'b1;
        end
        S_STOP_WR: begin
          if (depth_q != '0) depth_q <= depth_q - 1'b1;
          lns_q[tid_q]  <= wdata.span_ns;
          lcy_q[tid_q]  <= wdata.span_cyc;
          runs_q[tid_q] <= runs_q[tid_q] + 1'b1;
          if (fcnt_q[tid_q] < CNT_W'(RING_DEPTH)) fcnt_q[tid_q] <= fcnt_q[tid_q] + 1'b1;
        end
        S_TRESET: begin
          ctr_q <= ctr_q + 1'b1;
          slot_q[tid_q] <= '0;
          fcnt_q[tid_q] <= '0;
          runs_q[tid_q] <= '0;
          lns_q[tid_q]  <= '0;
          lcy_q[tid_q]  <= '0;
        end
        S_STAT_ACC: ctr_q <= ctr_q + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= operation_i;
      tid_q <= timer_id_i;
      tn_q  <= time_ns_i;
      cy_q  <= cycle_stamp_i;
    end
  end

  stsr_ring_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  stsr_stats_acc u_acc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (acc_clr),
    .en_i       (acc_en),
    .span_ns_i  (rdata.span_ns),
    .span_cyc_i (rdata.span_cyc),
    .stats_o    (stats)
  );

  assign status_o         = status_q;
  assign last_ns_o        = lns_q[tid_q];
  assign last_cyc_o       = lcy_q[tid_q];
  assign runs_done_o      = runs_q[tid_q];
  assign valid_samples_o  = stats.count;
  assign min_ns_o         = stats.min_ns;
  assign max_ns_o         = stats.max_ns;
  assign sum_ns_o         = stats.sum_ns;
  assign min_cyc_o        = stats.min_cyc;
  assign max_cyc_o        = stats.max_cyc;
  assign sum_cycles_o     = stats.sum_cyc;
  assign nest_level_o     = depth_q;

  `ASSERT_NXT(a_done_single, done_o, !done_o)
  `ASSERT_NXT(a_accept_busy, accept, busy)
  `ASSERT_IMP(a_clear_busy, state_q == S_CLEAR, busy && !done_o)
  `ASSERT_IMP(a_status_op, done_o && status_o, op_q == OP_STOP || op_q == OP_STATS)
endmodule
